/* design/cetc_pkg.sv */
// cetc_pkg: widths and fixed constants of the central european time converter
// no dependencies; used by cet_cest_time_conversion_core
package cetc_pkg;

  // field and internal widths
  localparam int unsigned TIME_W = 34;
  localparam int unsigned DAY_W  = 18;
  localparam int unsigned DOY_W  = 9;
  localparam int unsigned YOE_W  = 9;
  localparam int unsigned BND_W  = 36;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // seconds / 86400: drop 7 bits, then exact reciprocal of 675 (shift 37)
  localparam logic [27:0] RECIP_675   = 28'd203613265;
  // exact reciprocal of 1460 (shift 29) and 365 (shift 27) over 18-bit values
  localparam logic [18:0] RECIP_1460  = 19'd367720;
  localparam logic [18:0] RECIP_365   = 19'd367720;

  // calendar constants of the march based day count
  localparam logic [19:0] EPOCH_SHIFT = 20'd719468;
  localparam logic [19:0] ERA_DAYS4   = 20'd584388;
  localparam logic [19:0] ERA_DAYS5   = 20'd730485;
  localparam logic [19:0] ERA_DAYS6   = 20'd876582;
  localparam logic [8:0]  JAN_FIRST   = 9'd306;
  localparam logic [17:0] MAR31_OFS   = 18'd30;
  localparam logic [17:0] OCT31_OFS   = 18'd244;

  // offsets in seconds
  localparam logic [16:0] SECS_DAY    = 17'd86400;
  localparam logic [12:0] ONE_HOUR    = 13'd3600;
  localparam logic [12:0] TWO_HOURS   = 13'd7200;

endpackage

/* design/cet_cest_time_conversion_core.sv */
// cet_cest_time_conversion_core: utc <-> central european time, eu summer rule
// depends on cetc_pkg (scoped constants)

// Takes one item per clock cycle while the output is not stalled, through ten
// register stages (day quotient, day count and day of era, era quotients, leap
// days taken out, year of era, day of year, march and october anchors, last
// sundays, switch instants, offset). Stalls ripple back stage by stage, so
// empty stages fill while the output waits and stall_o rises only when all ten
// stages hold an item. Summer time is tested on the given time as if it were
// utc in both directions; results saturate at 0 and 2^34-1.
module cet_cest_time_conversion_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic        opcode_i,
  input  logic [33:0] time_in_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [33:0] time_out_o,
  output logic        summer_time_o
);

  localparam int unsigned NS = 10;

  // stage control
  logic [NS:1] v_q;
  logic [NS:1] ld;

  // item payload travelling with each stage
  logic [cetc_pkg::TIME_W-1:0] t_q [1:NS];
  logic [NS:1]                 op_q;

  // stage registers
  logic [54:0]                 p1_q;
  logic [cetc_pkg::DAY_W-1:0]  days2_q, doe2_q;
  logic [35:0]                 p2_q;
  logic [2:0]                  b3_q;
  logic                        c3_q;
  logic [cetc_pkg::DAY_W-1:0]  days3_q, doe3_q;
  logic [cetc_pkg::DAY_W-1:0]  n4_q, days4_q, doe4_q;
  logic [35:0]                 p3_q;
  logic [cetc_pkg::DAY_W-1:0]  days5_q, doe5_q;
  logic [cetc_pkg::YOE_W-1:0]  yoe6_q;
  logic [cetc_pkg::DOY_W-1:0]  doy6_q;
  logic [cetc_pkg::DAY_W-1:0]  days6_q;
  logic [cetc_pkg::DAY_W-1:0]  mar7_q, oct7_q;
  logic [cetc_pkg::DAY_W-1:0]  lsm8_q, lso8_q;
  logic [cetc_pkg::BND_W-1:0]  beg9_q, end9_q;
  logic [cetc_pkg::TIME_W-1:0] tout_q;
  logic                        summer_q;

  // next values
  logic [54:0]                 p1_d;
  logic [19:0]                 z2;
  logic [cetc_pkg::DAY_W-1:0]  days2_d, doe2_d;
  logic [35:0]                 p2_d;
  logic [2:0]                  b3_d;
  logic                        c3_d;
  logic [6:0]                  a4;
  logic [cetc_pkg::DAY_W-1:0]  n4_d;
  logic [35:0]                 p3_d;
  logic [cetc_pkg::YOE_W-1:0]  yoe6_d;
  logic [1:0]                  cent6;
  logic [cetc_pkg::DAY_W-1:0]  yb6;
  logic [cetc_pkg::DOY_W-1:0]  doy6_d;
  logic [9:0]                  yoe7;
  logic                        leap7, inc7;
  logic [18:0]                 mar1_7;
  logic [cetc_pkg::DAY_W-1:0]  mar7_d, oct7_d;
  logic [cetc_pkg::DAY_W-1:0]  lsm8_d, lso8_d;
  logic [cetc_pkg::BND_W-1:0]  beg9_d, end9_d;
  logic                        summer_d;
  logic [12:0]                 off10;
  logic [34:0]                 add10;
  logic [cetc_pkg::TIME_W-1:0] tout_d;

  // remainder modulo 7 by folding octal digits (8 = 1 mod 7)
  function automatic logic [2:0] mod7(input logic [18:0] v);
    logic [20:0] w;
    logic [5:0]  s;
    logic [3:0]  f;
    w = {2'b00, v};
    s = '0;
    for (int i = 0; i < 7; i++) begin
      s = s + 6'(w[3*i +: 3]);
    end
    f = 4'(s[5:3]) + 4'(s[2:0]);
    return (f >= 4'd7) ? 3'(f - 4'd7) : 3'(f);
  endfunction

  // stall chain: a stage loads when empty or when the next one moves
  always_comb begin
    ld[NS] = !v_q[NS] || !stall_i;
    for (int k = NS - 1; k >= 1; k--) begin
      ld[k] = !v_q[k] || ld[k+1];
    end
  end

  assign stall_o = !ld[1];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[1]) begin
        v_q[1] <= valid_i;
      end
      for (int k = 2; k <= NS; k++) begin
        if (ld[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // time and direction shift line
  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      t_q[1]  <= time_in_i;
      op_q[1] <= opcode_i;
    end
    for (int k = 2; k <= NS; k++) begin
      if (ld[k]) begin
        t_q[k]  <= t_q[k-1];
        op_q[k] <= op_q[k-1];
      end
    end
  end

  // stage 1: seconds / 128 times reciprocal of 675
  assign p1_d = 55'(time_in_i[33:7]) * 55'(cetc_pkg::RECIP_675);

  // stage 2: day count, then day of 400-year era (era is 4, 5 or 6)
  always_comb begin
    days2_d = p1_q[54:37];
    z2      = 20'(days2_d) + cetc_pkg::EPOCH_SHIFT;
    if (z2 >= cetc_pkg::ERA_DAYS6) begin
      doe2_d = cetc_pkg::DAY_W'(z2 - cetc_pkg::ERA_DAYS6);
    end else if (z2 >= cetc_pkg::ERA_DAYS5) begin
      doe2_d = cetc_pkg::DAY_W'(z2 - cetc_pkg::ERA_DAYS5);
    end else begin
      doe2_d = cetc_pkg::DAY_W'(z2 - cetc_pkg::ERA_DAYS4);
    end
  end

  // stage 3: doe / 1460 by reciprocal, doe / 36524 and doe / 146096 by compare
  always_comb begin
    p2_d = 36'(doe2_q) * 36'(cetc_pkg::RECIP_1460);
    if (doe2_q >= 18'd146096) begin
      b3_d = 3'd4;
    end else if (doe2_q >= 18'd109572) begin
      b3_d = 3'd3;
    end else if (doe2_q >= 18'd73048) begin
      b3_d = 3'd2;
    end else if (doe2_q >= 18'd36524) begin
      b3_d = 3'd1;
    end else begin
      b3_d = 3'd0;
    end
    c3_d = (doe2_q == 18'd146096);
  end

  // stage 4: day of era with leap days taken out
  always_comb begin
    a4   = p2_q[35:29];
    n4_d = doe3_q - 18'(a4) + 18'(b3_q) - 18'(c3_q);
  end

  // stage 5: year of era by reciprocal of 365
  assign p3_d = 36'(n4_q) * 36'(cetc_pkg::RECIP_365);

  // stage 6: day of the march based year
  always_comb begin
    yoe6_d = p3_q[35:27];
    if (yoe6_d >= 9'd300) begin
      cent6 = 2'd3;
    end else if (yoe6_d >= 9'd200) begin
      cent6 = 2'd2;
    end else if (yoe6_d >= 9'd100) begin
      cent6 = 2'd1;
    end else begin
      cent6 = 2'd0;
    end
    yb6    = 18'(yoe6_d) * 18'd365 + 18'(yoe6_d[8:2]) - 18'(cent6);
    doy6_d = cetc_pkg::DOY_W'(doe5_q - yb6);
  end

  // stage 7: march 1 of the civil year, then march 31 and october 31
  always_comb begin
    yoe7   = 10'(yoe6_q) + 10'd1;
    leap7  = (yoe7[1:0] == 2'b00) &&
             !(yoe7 == 10'd100 || yoe7 == 10'd200 || yoe7 == 10'd300);
    inc7   = (doy6_q >= cetc_pkg::JAN_FIRST);
    mar1_7 = 19'(days6_q) + (inc7 ? (19'd365 + 19'(leap7)) : 19'd0) - 19'(doy6_q);
    mar7_d = cetc_pkg::DAY_W'(mar1_7) + cetc_pkg::MAR31_OFS;
    oct7_d = cetc_pkg::DAY_W'(mar1_7) + cetc_pkg::OCT31_OFS;
  end

  // stage 8: last sunday on or before each anchor day
  assign lsm8_d = mar7_q - 18'(mod7(19'(mar7_q) + 19'd4));
  assign lso8_d = oct7_q - 18'(mod7(19'(oct7_q) + 19'd4));

  // stage 9: switch instants at 01:00 utc
  assign beg9_d = 36'(lsm8_q) * 36'(cetc_pkg::SECS_DAY) + 36'(cetc_pkg::ONE_HOUR);
  assign end9_d = 36'(lso8_q) * 36'(cetc_pkg::SECS_DAY) + 36'(cetc_pkg::ONE_HOUR);

  // stage 10: summer test, offset and saturation
  always_comb begin
    summer_d = (36'(t_q[9]) >= beg9_q) && (36'(t_q[9]) < end9_q);
    off10    = summer_d ? cetc_pkg::TWO_HOURS : cetc_pkg::ONE_HOUR;
    add10    = 35'(t_q[9]) + 35'(off10);
    if (!op_q[9]) begin
      tout_d = add10[34] ? cetc_pkg::TIME_MAX : add10[33:0];
    end else begin
      tout_d = (t_q[9] >= 34'(off10)) ? (t_q[9] - 34'(off10)) : '0;
    end
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      p1_q <= p1_d;
    end
    if (ld[2]) begin
      days2_q <= days2_d;
      doe2_q  <= doe2_d;
    end
    if (ld[3]) begin
      p2_q    <= p2_d;
      b3_q    <= b3_d;
      c3_q    <= c3_d;
      days3_q <= days2_q;
      doe3_q  <= doe2_q;
    end
    if (ld[4]) begin
      n4_q    <= n4_d;
      days4_q <= days3_q;
      doe4_q  <= doe3_q;
    end
    if (ld[5]) begin
      p3_q    <= p3_d;
      days5_q <= days4_q;
      doe5_q  <= doe4_q;
    end
    if (ld[6]) begin
      yoe6_q  <= yoe6_d;
      doy6_q  <= doy6_d;
      days6_q <= days5_q;
    end
    if (ld[7]) begin
      mar7_q <= mar7_d;
      oct7_q <= oct7_d;
    end
    if (ld[8]) begin
      lsm8_q <= lsm8_d;
      lso8_q <= lso8_d;
    end
    if (ld[9]) begin
      beg9_q <= beg9_d;
      end9_q <= end9_d;
    end
    if (ld[10]) begin
      tout_q   <= tout_d;
      summer_q <= summer_d;
    end
  end

  // outputs
  assign valid_o       = v_q[NS];
  assign time_out_o    = tout_q;
  assign summer_time_o = summer_q;

  // checks
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (&v_q))
    else $error("input stalled with an empty stage");

  a_year_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[6] |-> (yoe6_q < 9'd400) && (doy6_q < 9'd366))
    else $error("year of era or day of year out of range");

  a_sunday_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[8] |-> (lso8_q > lsm8_q))
    else $error("october switch not after march switch");

  a_summer_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !op_q[NS] && summer_time_o &&
     t_q[NS] < (cetc_pkg::TIME_MAX - 34'(cetc_pkg::TWO_HOURS)))
    |-> (time_out_o == t_q[NS] + 34'(cetc_pkg::TWO_HOURS)))
    else $error("summer item without two hour offset");

endmodule

/* sim/tb_cet_cest_time_conversion_core.sv */
// tb_cet_cest_time_conversion_core: self-checking bench for the cet/cest converter
// depends on cetc_pkg and cet_cest_time_conversion_core; directed then random items
`timescale 1ns / 1ps

module tb_cet_cest_time_conversion_core;

  localparam int unsigned TW          = cetc_pkg::TIME_W;
  localparam int unsigned CLK_PERIOD  = 12;
  localparam int unsigned RESET_LEN   = 12;
  localparam int unsigned IDLE_PCT    = 19;
  localparam int unsigned N_RANDOM    = 1900;
  localparam int unsigned QUIET_FIRST = 700;
  localparam int unsigned QUIET_LAST  = 1000;
  localparam int unsigned DRAIN_WAIT  = 24;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // direction codes
  localparam logic OP_TO_LOCAL = 1'b0;
  localparam logic OP_TO_UTC   = 1'b1;

  typedef logic [63:0] u64_t;

  localparam u64_t DAY_SECS  = 64'd86400;
  localparam u64_t HOUR_SECS = 64'd3600;
  localparam u64_t MAX_SECS  = u64_t'(cetc_pkg::TIME_MAX);

  typedef struct packed {
    logic          op;
    logic [TW-1:0] secs;
    logic          drain;
  } stamp_t;

  typedef struct packed {
    logic [TW-1:0] secs;
    logic          summer;
  } conv_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          valid_i = 1'b0;
  logic          stall_o;
  logic          opcode_i = 1'b0;
  logic [TW-1:0] time_in_i = '0;
  logic          valid_o;
  logic          stall_i = 1'b0;
  logic [TW-1:0] time_out_o;
  logic          summer_time_o;

  stamp_t        stamp_q[$];
  conv_t         conv_q[$];
  stamp_t        drv_stamp;
  conv_t         got_conv;
  logic          in_taken = 1'b0;
  int unsigned   sent_cnt = 0;
  int unsigned   hold_cnt = 0;
  int unsigned   cycle_cnt = 0;
  int unsigned   err_cnt = 0;
  logic          quiet;

  cet_cest_time_conversion_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_i),
    .stall_o       (stall_o),
    .opcode_i      (opcode_i),
    .time_in_i     (time_in_i),
    .valid_o       (valid_o),
    .stall_i       (stall_i),
    .time_out_o    (time_out_o),
    .summer_time_o (summer_time_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // day count since 1970 of a gregorian date, march to december
  function automatic u64_t day_of_date(input u64_t yr, input u64_t mon, input u64_t dom);
    u64_t era, yoe, doy, doe;
    era = yr / 400;
    yoe = yr - era * 400;
    doy = (153 * (mon - 3) + 2) / 5 + dom - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 64'd719468;
  endfunction

  // gregorian year of a day count since 1970
  function automatic u64_t year_of_day(input u64_t days);
    u64_t z, era, doe, yoe, doy, mp, yr;
    z   = days + 64'd719468;
    era = z / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    yr  = yoe + era * 400;
    if (mp >= 10) yr = yr + 1;
    return yr;
  endfunction

  // 01:00 utc on the last sunday of the month (31-day months only)
  function automatic u64_t switch_instant(input u64_t yr, input u64_t mon);
    u64_t d;
    d = day_of_date(yr, mon, 31);
    d = d - ((d + 4) % 7);
    return d * DAY_SECS + HOUR_SECS;
  endfunction

  // expected conversion of one item; rule tested on the input as utc both ways
  function automatic conv_t convert_stamp(input logic op, input logic [TW-1:0] secs_in);
    u64_t  t, yr, ofs, r;
    logic  summer;
    conv_t res;
    t      = u64_t'(secs_in);
    yr     = year_of_day(t / DAY_SECS);
    summer = (t >= switch_instant(yr, 3)) && (t < switch_instant(yr, 10));
    ofs    = summer ? 2 * HOUR_SECS : HOUR_SECS;
    if (op == OP_TO_LOCAL) begin
      r = t + ofs;
      if (r > MAX_SECS) r = MAX_SECS;
    end else begin
      r = (t >= ofs) ? t - ofs : 64'd0;
    end
    res.secs   = r[TW-1:0];
    res.summer = summer;
    return res;
  endfunction

  task automatic add_stamp(input logic op, input u64_t secs, input logic drain);
    stamp_t s;
    s.op    = op;
    s.secs  = secs[TW-1:0];
    s.drain = drain;
    stamp_q.push_back(s);
  endtask

  assign quiet = (sent_cnt >= QUIET_FIRST) && (sent_cnt < QUIET_LAST);

  // stimulus, reset and end of run
  initial begin : stim_gen
    u64_t yr, cand, on_at, off_at;
    int unsigned sel;
    // extremes, underflow and overflow
    add_stamp(OP_TO_LOCAL, 64'd0, 1'b0);
    add_stamp(OP_TO_UTC, 64'd0, 1'b0);
    add_stamp(OP_TO_UTC, HOUR_SECS - 1, 1'b0);
    add_stamp(OP_TO_UTC, HOUR_SECS, 1'b0);
    add_stamp(OP_TO_LOCAL, MAX_SECS, 1'b0);
    add_stamp(OP_TO_UTC, MAX_SECS, 1'b0);
    add_stamp(OP_TO_LOCAL, MAX_SECS - HOUR_SECS, 1'b0);
    add_stamp(OP_TO_LOCAL, MAX_SECS - 2 * HOUR_SECS, 1'b0);
    add_stamp(OP_TO_LOCAL, MAX_SECS - 2 * HOUR_SECS + 1, 1'b0);
    // start and end of summer, both directions
    on_at  = switch_instant(64'd2024, 3);
    off_at = switch_instant(64'd2024, 10);
    add_stamp(OP_TO_LOCAL, on_at - 1, 1'b0);
    add_stamp(OP_TO_LOCAL, on_at, 1'b0);
    add_stamp(OP_TO_LOCAL, off_at - 1, 1'b0);
    add_stamp(OP_TO_LOCAL, off_at, 1'b0);
    add_stamp(OP_TO_UTC, on_at - 1, 1'b0);
    add_stamp(OP_TO_UTC, on_at, 1'b0);
    add_stamp(OP_TO_UTC, off_at - 1, 1'b0);
    add_stamp(OP_TO_UTC, off_at, 1'b0);
    // century years, leap and not
    add_stamp(OP_TO_UTC, switch_instant(64'd2100, 3), 1'b0);
    add_stamp(OP_TO_LOCAL, switch_instant(64'd2100, 10) - 1, 1'b0);
    add_stamp(OP_TO_LOCAL, switch_instant(64'd2000, 3) - 1, 1'b0);
    add_stamp(OP_TO_UTC, switch_instant(64'd2000, 10), 1'b0);
    // new year boundary
    cand = day_of_date(64'd2024, 12, 31) * DAY_SECS;
    add_stamp(OP_TO_LOCAL, cand + DAY_SECS - 1, 1'b0);
    add_stamp(OP_TO_UTC, cand + DAY_SECS, 1'b0);

    // random part: whole range, near switch instants, near the ends
    for (int i = 0; i < N_RANDOM; i++) begin
      sel = $urandom_range(99);
      if (sel < 50) begin
        cand = {$urandom, $urandom};
        cand = cand & MAX_SECS;
      end else if (sel < 80) begin
        yr   = u64_t'($urandom_range(2514, 1970));
        cand = switch_instant(yr, ($urandom_range(1) == 1) ? 64'd3 : 64'd10);
        cand = cand + u64_t'($urandom_range(14400)) - 64'd7200;
        if (cand > MAX_SECS) cand = MAX_SECS - u64_t'($urandom_range(7200));
      end else if (sel < 90) begin
        cand = u64_t'($urandom_range(20000));
      end else begin
        cand = MAX_SECS - u64_t'($urandom_range(20000));
      end
      add_stamp(1'($urandom_range(1)), cand, (i == 0) || (i == N_RANDOM / 2));
    end

    // single reset at the start
    repeat (RESET_LEN) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // wait for all items to go in and all results to come back
    while (stamp_q.size() != 0 || valid_i) @(posedge clk_i);
    while (conv_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_cnt == 0 && conv_q.size() == 0) begin
      $display("tb_cet_cest_time_conversion_core: done, clean");
    end else begin
      $display("tb_cet_cest_time_conversion_core: done, errors");
    end
    $finish;
  end

  // input side: note acceptance and queue the expected result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= valid_i && !stall_o;
      if (valid_i && !stall_o) conv_q.push_back(convert_stamp(opcode_i, time_in_i));
    end
  end

  // driver: presents the next pending item, idles at random, holds for a drain
  always @(negedge clk_i) begin
    if (rst_ni && (!valid_i || in_taken)) begin
      if (stamp_q.size() != 0 && !(stamp_q[0].drain && conv_q.size() != 0) &&
          (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        drv_stamp = stamp_q.pop_front();
        valid_i   <= 1'b1;
        opcode_i  <= drv_stamp.op;
        time_in_i <= drv_stamp.secs;
        sent_cnt  <= sent_cnt + 1;
      end else begin
        valid_i <= 1'b0;
      end
    end
  end

  // output stall: random cycles plus the odd long burst to fill the pipe
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      stall_i <= 1'b0;
    end else if (hold_cnt != 0) begin
      stall_i  <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else if (quiet) begin
      stall_i <= 1'b0;
    end else if ($urandom_range(299) == 0) begin
      stall_i  <= 1'b1;
      hold_cnt <= $urandom_range(30, 12);
    end else begin
      stall_i <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  // monitor: compare each delivered item with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) begin
      if (conv_q.size() == 0) begin
        $error("unexpected result: time_out %0d summer_time %0b", time_out_o, summer_time_o);
        err_cnt = err_cnt + 1;
      end else begin
        got_conv = conv_q.pop_front();
        if (time_out_o !== got_conv.secs) begin
          $error("time_out: expected %0d, actual %0d", got_conv.secs, time_out_o);
          err_cnt = err_cnt + 1;
        end
        if (summer_time_o !== got_conv.summer) begin
          $error("summer_time: expected %0b, actual %0b", got_conv.summer, summer_time_o);
          err_cnt = err_cnt + 1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_cet_cest_time_conversion_core: done, errors");
      $finish;
    end
  end

endmodule
